// ===== hw/rtl/radial_brush_grid_stamp_defines.svh =====
// Assertion macros shared by the grid stamp RTL.
// No dependencies; included by modules that check their own logic.
`ifndef RADIAL_BRUSH_GRID_STAMP_DEFINES_SVH
`define RADIAL_BRUSH_GRID_STAMP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RBGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RBGS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RBGS_ASSERT(label, clk, rst_n, prop, msg)
`define RBGS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/rbgs_pkg.sv =====
// Shared types, constants and falloff tables of the grid stamp block.
// No dependencies.
`default_nettype none
package rbgs_pkg;
    localparam int MaxRows    = 64;
    localparam int MaxColumns = 64;
    localparam int MaxRadius  = 4;
    localparam int RowW   = $clog2(MaxRows);
    localparam int ColW   = $clog2(MaxColumns);
    localparam int AddrW  = RowW + ColW;
    localparam int Depth  = MaxRows * MaxColumns;
    localparam int LevelW = 11;
    localparam logic [LevelW-1:0] FullLevel  = 11'd1024;
    localparam logic [LevelW-1:0] PaintLevel = 11'd819;

    localparam logic [1:0] OpStamp = 2'd0;
    localparam logic [1:0] OpClear = 2'd1;
    localparam logic [1:0] OpRead  = 2'd2;

    localparam logic [2:0] CfgOriginX = 3'd0;
    localparam logic [2:0] CfgOriginY = 3'd1;
    localparam logic [2:0] CfgCellW   = 3'd2;
    localparam logic [2:0] CfgCellH   = 3'd3;
    localparam logic [2:0] CfgRows    = 3'd4;
    localparam logic [2:0] CfgCols    = 3'd5;

    // kind of work handed to the back end
    typedef enum logic [1:0] {
        JOB_ACK   = 2'd0,
        JOB_STAMP = 2'd1,
        JOB_CLEAR = 2'd2,
        JOB_READ  = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t       kind;
        logic            paint;
        logic [2:0]      radius;
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
    } job_t;

    typedef struct packed {
        logic [RowW-1:0]   cell_row;
        logic [ColW-1:0]   cell_col;
        logic [LevelW-1:0] level;
        logic              valid_res;
        logic              last;
    } res_t;

    // change for a squared distance s at radius r
    function automatic logic [8:0] falloff(input logic paint, input logic [2:0] r,
                                           input logic [4:0] s);
        logic [8:0] v;
        v = 9'd0;
        case (r)
            3'd1: if (s == 5'd0) v = paint ? 9'd205 : 9'd307;
            3'd2: begin
                case (s)
                    5'd0: v = paint ? 9'd205 : 9'd307;
                    5'd1: v = paint ? 9'd26 : 9'd38;
                    5'd2: v = paint ? 9'd5 : 9'd8;
                    default: v = 9'd0;
                endcase
            end
            3'd3: begin
                case (s)
                    5'd0: v = paint ? 9'd205 : 9'd307;
                    5'd1: v = paint ? 9'd61 : 9'd91;
                    5'd2: v = paint ? 9'd30 : 9'd45;
                    5'd4: v = paint ? 9'd8 : 9'd11;
                    5'd5: v = paint ? 9'd3 : 9'd5;
                    default: v = 9'd0;
                endcase
            end
            3'd4: begin
                case (s)
                    5'd0:  v = paint ? 9'd205 : 9'd307;
                    5'd1:  v = paint ? 9'd86 : 9'd130;
                    5'd2:  v = paint ? 9'd55 : 9'd83;
                    5'd4:  v = paint ? 9'd26 : 9'd38;
                    5'd5:  v = paint ? 9'd18 : 9'd26;
                    5'd8:  v = paint ? 9'd5 : 9'd8;
                    5'd9:  v = paint ? 9'd3 : 9'd5;
                    5'd10: v = paint ? 9'd2 : 9'd3;
                    default: v = 9'd0;
                endcase
            end
            default: v = 9'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rbgs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module rbgs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rbgs_front.sv =====
// Front end: accepts requests, maps the cursor to a cell and pushes a job.
// Depends on rbgs_pkg; cursor division is a restoring divider, one bit a cycle.
`default_nettype none
module rbgs_front
    import rbgs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] cursor_x,
    input  wire logic [15:0] cursor_y,
    input  wire logic        paint,
    input  wire logic [2:0]  radius,
    input  wire logic [5:0]  read_row,
    input  wire logic [5:0]  read_col,
    input  wire logic [15:0] origin_x,
    input  wire logic [15:0] origin_y,
    input  wire logic [12:0] cell_w,
    input  wire logic [12:0] cell_h,
    input  wire logic [6:0]  rows_used,
    input  wire logic [6:0]  cols_used,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [16:0] qx_reg, qy_reg;      // magnitude, shifted into quotient
    logic [12:0] rx_reg, ry_reg;
    logic        nx_reg, ny_reg;      // offset negative
    logic [4:0]  cnt_reg;
    job_t        job_reg;

    logic signed [16:0] dx, dy;
    assign dx = 17'(signed'(cursor_x)) - 17'(signed'(origin_x));
    assign dy = 17'(signed'(cursor_y)) - 17'(signed'(origin_y));

    // one restoring step for each axis
    logic [13:0] tx, ty;
    assign tx = {rx_reg, qx_reg[16]} - {1'b0, cell_w};
    assign ty = {ry_reg, qy_reg[16]} - {1'b0, cell_h};

    // cell check once quotient is complete; nonzero sign with nonzero q is out
    logic in_x, in_y;
    assign in_x = (!nx_reg || qx_reg == 17'd0) && (qx_reg < 17'(cols_used));
    assign in_y = (!ny_reg || qy_reg == 17'd0) && (qy_reg < 17'(rows_used));

    logic [2:0] rsat;
    assign rsat = (radius > 3'(MaxRadius)) ? 3'(MaxRadius) : radius;

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job       = job_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (in_valid && op == OpStamp && rsat != 3'd0 &&
                         cell_w != 13'd0 && cell_h != 13'd0) state_next = F_DIV;
                     else if (in_valid) state_next = F_PUSH;
            F_DIV:   if (cnt_reg == 5'd17) state_next = F_PUSH;
            F_PUSH:  if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            F_IDLE: begin
                qx_reg  <= dx[16] ? 17'(-dx) : 17'(dx);
                qy_reg  <= dy[16] ? 17'(-dy) : 17'(dy);
                nx_reg  <= dx[16];
                ny_reg  <= dy[16];
                rx_reg  <= '0;
                ry_reg  <= '0;
                cnt_reg <= '0;
                job_reg.paint  <= paint;
                job_reg.radius <= rsat;
                job_reg.row    <= read_row;
                job_reg.col    <= read_col;
                case (op)
                    OpClear: job_reg.kind <= JOB_CLEAR;
                    OpRead:  job_reg.kind <= JOB_READ;
                    default: job_reg.kind <= JOB_ACK;
                endcase
            end
            F_DIV: begin
                // 17 steps cover the full 17-bit magnitude
                if (cnt_reg == 5'd17) begin
                    job_reg.kind <= (in_x && in_y) ? JOB_STAMP : JOB_ACK;
                    job_reg.row  <= qy_reg[RowW-1:0];
                    job_reg.col  <= qx_reg[ColW-1:0];
                end else begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (!tx[13]) begin
                        rx_reg <= tx[12:0];
                        qx_reg <= {qx_reg[15:0], 1'b1};
                    end else begin
                        rx_reg <= {rx_reg[11:0], qx_reg[16]};
                        qx_reg <= {qx_reg[15:0], 1'b0};
                    end
                    if (!ty[13]) begin
                        ry_reg <= ty[12:0];
                        qy_reg <= {qy_reg[15:0], 1'b1};
                    end else begin
                        ry_reg <= {ry_reg[11:0], qy_reg[16]};
                        qy_reg <= {qy_reg[15:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rbgs_back.sv =====
// Back end: walks the stamp window with read-modify-write, clears, reads.
// Depends on rbgs_pkg, rbgs_ram and the assertion macro header.
`default_nettype none
`include "radial_brush_grid_stamp_defines.svh"
module rbgs_back
    import rbgs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       job_valid,
    output logic            job_ready,
    input  job_t            job,
    input  wire logic [6:0] rows_used,
    input  wire logic [6:0] cols_used,
    output logic            res_valid,
    input  wire logic       res_ready,
    output res_t            res
);
    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_SCAN  = 7'b0000010,
        B_RD    = 7'b0000100,
        B_MOD   = 7'b0001000,
        B_OUT   = 7'b0010000,
        B_CLEAR = 7'b0100000,
        B_RDOUT = 7'b1000000
    } bstate_t;

    bstate_t   state_reg;
    job_t      jb_reg;
    logic signed [3:0] di_reg, dj_reg;  // window offsets
    logic      any_reg;
    logic [AddrW-1:0] clr_reg;
    res_t      res_reg;
    res_t      hold_reg;                // newest cell, held until next or end
    logic      rv_reg;

    // window cell under the current offsets
    logic signed [8:0] ci, cj;
    assign ci = 9'(jb_reg.row) + 9'(di_reg);
    assign cj = 9'(jb_reg.col) + 9'(dj_reg);
    logic [4:0] sq;
    logic [7:0] sq8;
    assign sq8 = 8'(di_reg * di_reg) + 8'(dj_reg * dj_reg);
    assign sq  = sq8[4:0];
    logic [5:0] rr;
    assign rr = 6'(jb_reg.radius) * 6'(jb_reg.radius);
    logic hit;
    assign hit = !ci[8] && !cj[8] && ci < 9'(rows_used) && cj < 9'(cols_used) &&
                 (8'(sq8) < 8'(rr));
    logic last_pos;
    assign last_pos = (di_reg == 4'(jb_reg.radius)) && (dj_reg == 4'(jb_reg.radius));

    logic [AddrW-1:0] addr;
    assign addr = {ci[RowW-1:0], cj[ColW-1:0]};

    logic             we;
    logic [AddrW-1:0] waddr, raddr;
    logic [LevelW-1:0] wdata, rdata;
    rbgs_ram #(.Width(LevelW), .Depth(Depth)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // modify
    logic [8:0]  dv;
    logic [11:0] sum;
    logic [LevelW-1:0] newv;
    assign dv  = falloff(jb_reg.paint, jb_reg.radius, sq);
    assign sum = 12'(rdata) + 12'(dv);
    always_comb begin
        if (jb_reg.paint) begin
            newv = (sum > 12'(FullLevel)) ? FullLevel : sum[LevelW-1:0];
        end else begin
            newv = (rdata > 11'(dv)) ? rdata - 11'(dv) : '0;
        end
    end

    // output slot is free, or empties this cycle
    logic out_free;
    assign out_free = !rv_reg || res_ready;

    // a new result enters the output slot
    logic rv_set;
    always_comb begin
        case (state_reg)
            B_IDLE:  rv_set = job_valid && !rv_reg && (job.kind == JOB_ACK);
            B_MOD:   rv_set = out_free && any_reg;
            B_OUT:   rv_set = out_free;
            B_RDOUT: rv_set = out_free;
            default: rv_set = 1'b0;
        endcase
    end

    assign we    = ((state_reg == B_MOD) && out_free) || (state_reg == B_CLEAR);
    assign waddr = (state_reg == B_CLEAR) ? clr_reg : addr;
    assign wdata = (state_reg == B_CLEAR) ? (jb_reg.paint ? PaintLevel : '0) : newv;
    assign raddr = (state_reg == B_IDLE) ? {job.row, job.col} : addr;

    assign job_ready = (state_reg == B_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLEAR;
            rv_reg    <= 1'b0;
            clr_reg   <= '0;
            jb_reg.paint <= 1'b0;
            jb_reg.kind  <= JOB_ACK;
        end else begin
            rv_reg <= rv_set || (rv_reg && !res_ready);
            case (state_reg)
                B_IDLE: if (job_valid && !rv_reg) begin
                    jb_reg  <= job;
                    di_reg  <= -4'(job.radius);
                    dj_reg  <= -4'(job.radius);
                    any_reg <= 1'b0;
                    clr_reg <= '0;
                    case (job.kind)
                        JOB_STAMP: state_reg <= B_SCAN;
                        JOB_CLEAR: state_reg <= B_CLEAR;
                        JOB_READ:  state_reg <= B_RDOUT;
                        default: begin
                            res_reg <= '{default: '0, last: 1'b1};
                        end
                    endcase
                end
                B_SCAN: begin
                    if (hit) begin
                        state_reg <= B_RD;
                    end else if (last_pos) begin
                        state_reg <= B_OUT;
                    end else begin
                        if (dj_reg == 4'(jb_reg.radius)) begin
                            dj_reg <= -4'(jb_reg.radius);
                            di_reg <= di_reg + 4'sd1;
                        end else begin
                            dj_reg <= dj_reg + 4'sd1;
                        end
                    end
                end
                B_RD: state_reg <= B_MOD;
                B_MOD: begin
                    // previous cell goes out; this one is held, it may be the last
                    if (out_free) begin
                        if (any_reg) begin
                            res_reg <= hold_reg;
                        end
                        any_reg <= 1'b1;
                        hold_reg.cell_row  <= ci[RowW-1:0];
                        hold_reg.cell_col  <= cj[ColW-1:0];
                        hold_reg.level     <= newv;
                        hold_reg.valid_res <= 1'b1;
                        hold_reg.last      <= 1'b0;
                        if (last_pos) begin
                            state_reg <= B_OUT;
                        end else begin
                            state_reg <= B_SCAN;
                            if (dj_reg == 4'(jb_reg.radius)) begin
                                dj_reg <= -4'(jb_reg.radius);
                                di_reg <= di_reg + 4'sd1;
                            end else begin
                                dj_reg <= dj_reg + 4'sd1;
                            end
                        end
                    end else begin
                        state_reg <= B_RD;
                    end
                end
                B_OUT: if (out_free) begin
                    if (!any_reg) begin
                        res_reg <= '{default: '0, last: 1'b1};
                    end else begin
                        res_reg <= '{cell_row: hold_reg.cell_row,
                                     cell_col: hold_reg.cell_col,
                                     level: hold_reg.level,
                                     valid_res: 1'b1,
                                     last: 1'b1};
                    end
                    state_reg <= B_IDLE;
                end
                B_CLEAR: begin
                    clr_reg <= clr_reg + AddrW'(1);
                    // a requested clear is acknowledged, the reset sweep ends silently
                    if (clr_reg == AddrW'(Depth - 1)) begin
                        if (jb_reg.kind == JOB_CLEAR) begin
                            state_reg <= B_OUT;
                            any_reg   <= 1'b0;
                        end else begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                B_RDOUT: if (out_free) begin
                    res_reg.cell_row <= jb_reg.row;
                    res_reg.cell_col <= jb_reg.col;
                    res_reg.last     <= 1'b1;
                    if (7'(jb_reg.row) < rows_used && 7'(jb_reg.col) < cols_used) begin
                        res_reg.level     <= rdata;
                        res_reg.valid_res <= 1'b1;
                    end else begin
                        res_reg.level     <= '0;
                        res_reg.valid_res <= 1'b0;
                    end
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    `RBGS_ASSERT(a_onehot, aclk, aresetn, $onehot(state_reg), "back state not one-hot")
    `RBGS_ASSERT(a_noacc_busy, aclk, aresetn, job_ready |-> state_reg == B_IDLE, "job taken while busy")
    `RBGS_ASSERT(a_we_mod, aclk, aresetn, (state_reg == B_MOD) |-> $past(state_reg) == B_RD, "write without read")
endmodule
`default_nettype wire

// ===== hw/rtl/radial_brush_grid_stamp.sv =====
// Radial brush grid stamp: a 64x64 grid of 11-bit intensities (1024 = full) that
// a circular brush paints or erases. A stamp is first mapped to a cell by the
// front-end divider (one quotient bit a cycle, 17 bits); the back end then walks
// every window position and does a read-modify-write on the store for each
// touched cell. The front end can take and divide the next request while the
// back end works. A clear sweeps all 4096 cells, one a cycle; after reset the
// same sweep runs before the back end serves the first request. Every request
// returns at least one result; the last carries last = 1.
// Depends on rbgs_pkg, rbgs_front, rbgs_back, rbgs_ram.
`default_nettype none
module radial_brush_grid_stamp
    import rbgs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: cursor_x[15:0], cursor_y[31:16], radius[34:32], read_row[40:35],
    // read_col[46:41], zero pad [47]
    input  wire logic [47:0] s_tdata,
    // tuser: op[1:0], paint[2]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: cell_row[5:0], cell_col[11:6], level[22:12], zero pad [23]
    output logic [23:0]      m_tdata,
    // tuser: valid_res
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0] org_x_reg, org_y_reg;
    logic [12:0] cw_reg, ch_reg;
    logic [6:0]  rows_reg, cols_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            cw_reg    <= 13'd16;
            ch_reg    <= 13'd16;
            rows_reg  <= 7'd28;
            cols_reg  <= 7'd28;
        end else if (cfg_valid) begin
            case (cfg_index)
                CfgOriginX: org_x_reg <= cfg_data;
                CfgOriginY: org_y_reg <= cfg_data;
                CfgCellW:   cw_reg    <= cfg_data[12:0];
                CfgCellH:   ch_reg    <= cfg_data[12:0];
                CfgRows:    rows_reg  <= cfg_data[6:0];
                CfgCols:    cols_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [6:0] rows_used, cols_used;
    assign rows_used = (rows_reg > 7'(MaxRows)) ? 7'(MaxRows) : rows_reg;
    assign cols_used = (cols_reg > 7'(MaxColumns)) ? 7'(MaxColumns) : cols_reg;

    logic job_valid, job_ready;
    job_t job;
    res_t res;

    rbgs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .op(s_tuser[1:0]), .cursor_x(s_tdata[15:0]), .cursor_y(s_tdata[31:16]),
        .paint(s_tuser[2]), .radius(s_tdata[34:32]),
        .read_row(s_tdata[40:35]), .read_col(s_tdata[46:41]),
        .origin_x(org_x_reg), .origin_y(org_y_reg),
        .cell_w(cw_reg), .cell_h(ch_reg),
        .rows_used(rows_used), .cols_used(cols_used),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    rbgs_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .rows_used(rows_used), .cols_used(cols_used),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {1'b0, res.level, res.cell_col, res.cell_row};
    assign m_tuser = res.valid_res;
    assign m_tlast = res.last;

    logic unused_ok;
    assign unused_ok = s_tdata[47];
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for radial_brush_grid_stamp: random and directed stamp, clear and read
// requests checked against a behavioral grid model. Depends on rbgs_pkg and the RTL.
`timescale 1ns / 1ps

class grid_scoreboard;
    typedef struct {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [10:0] level;
        logic        vres;
        logic        last;
    } cell_report_t;

    cell_report_t pending[$];
    logic [10:0]  cells[4096];
    int           org_x, org_y;
    int           cw, ch, nrows, ncols;
    int           errors;

    function new();
        foreach (cells[k]) cells[k] = '0;
        org_x = 0; org_y = 0; cw = 16; ch = 16; nrows = 28; ncols = 28;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            rbgs_pkg::CfgOriginX: org_x = $signed(val);
            rbgs_pkg::CfgOriginY: org_y = $signed(val);
            rbgs_pkg::CfgCellW:   cw = val[12:0];
            rbgs_pkg::CfgCellH:   ch = val[12:0];
            rbgs_pkg::CfgRows:    nrows = val[6:0];
            rbgs_pkg::CfgCols:    ncols = val[6:0];
            default: ;
        endcase
    endfunction

    function void push(int r, int c, int lv, bit v, bit l);
        cell_report_t e;
        e.row = r[5:0]; e.col = c[5:0]; e.level = lv[10:0]; e.vres = v; e.last = l;
        pending.push_back(e);
    endfunction

    // brush falloff for a squared distance, rounded cubic profile
    function int falloff(bit paint, int r, int s);
        int addv[5][16] = '{'{default:0}, '{0:205, default:0},
            '{0:205, 1:26, 2:5, default:0},
            '{0:205, 1:61, 2:30, 4:8, 5:3, default:0},
            '{0:205, 1:86, 2:55, 4:26, 5:18, 8:5, 9:3, 10:2, default:0}};
        int subv[5][16] = '{'{default:0}, '{0:307, default:0},
            '{0:307, 1:38, 2:8, default:0},
            '{0:307, 1:91, 2:45, 4:11, 5:5, default:0},
            '{0:307, 1:130, 2:83, 4:38, 5:26, 8:8, 9:5, 10:3, default:0}};
        return paint ? addv[r][s & 15] : subv[r][s & 15];
    endfunction

    // works out the results of one accepted request
    function void note_request(logic [1:0] op, logic [15:0] cx, logic [15:0] cy,
                               bit paint, logic [2:0] rad, logic [5:0] rr, logic [5:0] rc);
        int nr, nc, r, row, col, n, s, v, dv, idx;
        nr = nrows < 64 ? nrows : 64;
        nc = ncols < 64 ? ncols : 64;
        n = 0;
        case (op)
            rbgs_pkg::OpStamp: begin
                r = rad > 4 ? 4 : rad;
                if (r > 0 && cw != 0 && ch != 0) begin
                    row = ($signed(cy) - org_y) / ch;
                    col = ($signed(cx) - org_x) / cw;
                    if (row >= 0 && col >= 0 && row < nr && col < nc)
                        for (int i = row - r; i <= row + r; i++)
                            for (int j = col - r; j <= col + r; j++) begin
                                s = (i - row) * (i - row) + (j - col) * (j - col);
                                if (i < 0 || j < 0 || i >= nr || j >= nc || s >= r * r)
                                    continue;
                                idx = i * 64 + j;
                                v = cells[idx];
                                dv = falloff(paint, r, s);
                                if (paint) v = (v + dv > 1024) ? 1024 : v + dv;
                                else v = (v > dv) ? v - dv : 0;
                                cells[idx] = 11'(v);
                                push(i, j, v, 1'b1, 1'b0);
                                n++;
                            end
                end
                if (n > 0) pending[$].last = 1'b1;
                else push(0, 0, 0, 1'b0, 1'b1);
            end
            rbgs_pkg::OpClear: begin
                foreach (cells[k]) cells[k] = paint ? rbgs_pkg::PaintLevel : '0;
                push(0, 0, 0, 1'b0, 1'b1);
            end
            rbgs_pkg::OpRead: begin
                if (rr < nr && rc < nc) push(rr, rc, cells[rr * 64 + rc], 1'b1, 1'b1);
                else push(rr, rc, 0, 1'b0, 1'b1);
            end
            default: push(0, 0, 0, 1'b0, 1'b1);
        endcase
    endfunction

    function void check_result(logic [23:0] data, logic vres, logic last);
        cell_report_t e;
        if (pending.size() == 0) begin
            $error("result with none expected: %h", data);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (data[5:0] !== e.row) begin
            $error("cell_row exp %0d got %0d", e.row, data[5:0]); errors++;
        end
        if (data[11:6] !== e.col) begin
            $error("cell_col exp %0d got %0d", e.col, data[11:6]); errors++;
        end
        if (data[22:12] !== e.level) begin
            $error("level exp %0d got %0d", e.level, data[22:12]); errors++;
        end
        if (vres !== e.vres) begin
            $error("valid_res exp %0d got %0d", e.vres, vres); errors++;
        end
        if (last !== e.last) begin
            $error("last exp %0d got %0d", e.last, last); errors++;
        end
    endfunction
endclass

module tb;
    import rbgs_pkg::*;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser, m_tlast;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    grid_scoreboard grid;
    bit  calm;        // no idling on either side
    int  cycles;

    radial_brush_grid_stamp dut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // hard stop: reset sweep plus 210+ requests at worst case with stalls
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 600000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random stall bursts, check on each accepted result
    initial begin
        int gap;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (!calm && gap == 0 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
            if (gap > 0) begin
                gap--;
                m_tready <= 0;
            end else m_tready <= 1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) grid.check_result(m_tdata, m_tuser, m_tlast);

    // drop the request line after the last accepted request
    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        idle_input();
        // idle until the block has drained its last request
        while (grid.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        grid.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // returns at the accepting edge; the next call or idle_input moves the line
    task automatic send(logic [1:0] op, logic [15:0] cx, logic [15:0] cy, bit paint,
                        logic [2:0] rad, logic [5:0] rr, logic [5:0] rc);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= {paint, op};
        s_tdata  <= {1'b0, rc, rr, rad, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        grid.note_request(op, cx, cy, paint, rad, rr, rc);
    endtask

    // stamp aimed at a cell under the current setting, plus jitter inside it
    task automatic stamp_at(int row, int col, bit paint, logic [2:0] rad);
        int x, y;
        x = grid.org_x + col * grid.cw + $urandom_range(0, grid.cw - 1);
        y = grid.org_y + row * grid.ch + $urandom_range(0, grid.ch - 1);
        send(OpStamp, x[15:0], y[15:0], paint, rad, '0, '0);
    endtask

    task automatic random_phase(int count);
        int pick, nr, nc;
        for (int k = 0; k < count; k++) begin
            nr = grid.nrows; nc = grid.ncols;
            pick = $urandom_range(0, 19);
            if (pick < 12)
                stamp_at($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                         1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            else if (pick < 13)
                send(OpClear, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     3'($urandom), 6'($urandom), 6'($urandom));
            else if (pick < 17)
                send(OpRead, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     3'($urandom), 6'($urandom_range(0, nr)), 6'($urandom_range(0, nc)));
            else if (pick < 18)
                send(2'd3, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     3'($urandom), 6'($urandom), 6'($urandom));
            else
                send(OpStamp, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     3'($urandom), 6'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        grid = new();
        calm = 0;
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1;

        // directed: edges of the grid, all radii, saturation, clamps, reads
        stamp_at(0, 0, 1'b1, 3'd4);
        stamp_at(27, 27, 1'b1, 3'd7);
        stamp_at(5, 5, 1'b0, 3'd0);
        for (int k = 0; k < 6; k++) stamp_at(10, 10, 1'b1, 3'd1);
        stamp_at(10, 10, 1'b0, 3'd4);
        stamp_at(10, 10, 1'b0, 3'd3);
        stamp_at(10, 10, 1'b0, 3'd2);
        send(OpRead, '0, '0, 1'b0, '0, 6'd10, 6'd10);
        send(OpRead, '0, '0, 1'b0, '0, 6'd63, 6'd63);
        send(OpStamp, 16'h8000, 16'h7fff, 1'b1, 3'd2, '0, '0);
        send(OpStamp, 16'hfff8, 16'hfff8, 1'b1, 3'd2, '0, '0);  // just above-left: cell 0
        send(OpStamp, 16'h7fff, 16'h8000, 1'b0, 3'd2, '0, '0);
        send(2'd3, 16'hffff, 16'hffff, 1'b1, 3'd7, 6'h3f, 6'h3f);
        send(OpClear, '0, '0, 1'b1, '0, '0, '0);
        send(OpRead, '0, '0, 1'b0, '0, 6'd40, 6'd40);
        stamp_at(3, 3, 1'b1, 3'd4);
        send(OpClear, '0, '0, 1'b0, '0, '0, '0);
        send(OpRead, '0, '0, 1'b0, '0, 6'd3, 6'd3);

        random_phase(40);
        // full grid, unit cells, negative origin
        write_reg(CfgRows, 16'd64);
        write_reg(CfgCols, 16'd64);
        write_reg(CfgCellW, 16'd1);
        write_reg(CfgCellH, 16'd1);
        write_reg(CfgOriginX, 16'h8000);
        write_reg(CfgOriginY, 16'hffc0);
        random_phase(50);
        // tiny grid, huge cells, positive origin
        write_reg(CfgRows, 16'd1);
        write_reg(CfgCols, 16'd3);
        write_reg(CfgCellW, 16'd4096);
        write_reg(CfgCellH, 16'd4095);
        write_reg(CfgOriginX, 16'h7fff);
        write_reg(CfgOriginY, 16'h1234);
        random_phase(30);
        // mid-size, odd cells
        write_reg(CfgRows, 16'd37);
        write_reg(CfgCols, 16'd50);
        write_reg(CfgCellW, 16'd7);
        write_reg(CfgCellH, 16'd3);
        write_reg(CfgOriginX, 16'h00a5);
        write_reg(CfgOriginY, 16'hff5a);
        random_phase(45);
        calm = 1;
        random_phase(25);
        idle_input();

        while (grid.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (grid.errors == 0 && grid.pending.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
